[rtl/mexp_pkg.sv]
// mexp_pkg: widths shared by the modular exponentiation block and its
// checker, plus the reset value and the bit-serial modular step of the block.
// No dependencies.
`default_nettype none

package mexp_pkg;

   localparam int MOD_WIDTH     = 32;
   localparam int EXP_WIDTH     = 63;
   localparam int BASE_WIDTH    = 32;
   localparam int RESULT_WIDTH  = 32;
   localparam int REQ_WIDTH     = ((BASE_WIDTH + EXP_WIDTH + 7) / 8) * 8;
   localparam int CNT_WIDTH     = $clog2(BASE_WIDTH);

   localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = MOD_WIDTH'(1000000007);

   // One MSB-first step of interleaved modular multiplication:
   // returns (2*r + (b ? y : 0)) mod m, with r < m and y <= m.
   function automatic logic [MOD_WIDTH-1:0] mod_step(
      input logic [MOD_WIDTH-1:0] r,
      input logic                 b,
      input logic [MOD_WIDTH-1:0] y,
      input logic [MOD_WIDTH:0]   m
   );
      logic [MOD_WIDTH:0] d;
      logic [MOD_WIDTH:0] s;
      d = {r, 1'b0};
      if (d >= m) begin
         d = d - m;
      end
      s = {1'b0, d[MOD_WIDTH-1:0]} + (b ? {1'b0, y} : {(MOD_WIDTH + 1){1'b0}});
      if (s >= m) begin
         s = s - m;
      end
      return s[MOD_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/modular_exponentiation.sv]
// Modular exponentiation: base^exponent mod modulus, square-and-multiply with
// bit-serial modular multipliers. Depends on mexp_pkg.
//
// Usage:
//   req_* beat: base_value and exponent. rsp_* beat: power_result.
//   csr_wr_en/csr_wr_data write the modulus; write it only while idle.
//   A modulus of zero reduces modulo 2^MOD_WIDTH.
// Throughput:
//   One item at a time. An exponent of zero goes straight to the result.
//   Otherwise the base is first reduced by the modulus, then each exponent bit up
//   to its highest set bit takes one pass over the base bits (square and multiply
//   run side by side, one base bit per cycle).
//   The one-bit-per-cycle add/compare sets the rate.
// Reset:
//   Synchronous, active high. Modulus returns to 1000000007; no result is
//   pending and the block is ready for a new beat.
// Stall:
//   The result sits in an output register. While the receiver stalls, a
//   finished result waits in the core and req_tready stays low; a new beat
//   is taken once the core has handed its result to the output register.
`default_nettype none

module modular_exponentiation (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [mexp_pkg::MOD_WIDTH-1:0]    csr_wr_data,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // base_value [31:0], exponent [EXP_WIDTH+31:32], zero fill above
   input  wire logic [mexp_pkg::REQ_WIDTH-1:0]    req_tdata,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // power_result [31:0]
   output      logic [mexp_pkg::RESULT_WIDTH-1:0] rsp_tdata
);

   localparam int MW = mexp_pkg::MOD_WIDTH;
   localparam int EW = mexp_pkg::EXP_WIDTH;
   localparam int BW = mexp_pkg::BASE_WIDTH;
   localparam int CW = mexp_pkg::CNT_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MULT,
      ST_FINISH
   } state_type;

   state_type                         state_ff;
   logic [MW-1:0]                     modulus_ff;
   logic [BW-1:0]                     shift_ff;
   logic [EW-1:0]                     exp_ff;
   logic [CW-1:0]                     cnt_ff;
   logic [MW-1:0]                     base_ff;
   logic [MW-1:0]                     acc_ff;
   logic [MW-1:0]                     sq_ff;
   logic [MW-1:0]                     ac_ff;
   logic                              rsp_valid_ff;
   logic [mexp_pkg::RESULT_WIDTH-1:0] rsp_data_ff;

   logic [MW:0]                       mod_full;
   logic [MW-1:0]                     sq_in;
   logic [MW-1:0]                     ac_in;
   logic [MW-1:0]                     sq_addend;
   logic [BW-1:0]                     req_base;
   logic [EW-1:0]                     req_exp;
   logic                              req_fire;
   logic                              out_free;

   assign mod_full   = {(modulus_ff == '0), modulus_ff};
   assign req_base   = req_tdata[BW-1:0];
   assign req_exp    = req_tdata[BW +: EW];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // during reduction the base is multiplied by one
   assign sq_addend = (state_ff == ST_REDUCE) ? MW'(1) : base_ff;
   assign sq_in = mexp_pkg::mod_step(sq_ff, shift_ff[BW-1], sq_addend, mod_full);
   assign ac_in = mexp_pkg::mod_step(ac_ff, shift_ff[BW-1], acc_ff, mod_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         modulus_ff   <= mexp_pkg::MODULUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            modulus_ff <= csr_wr_data;
         end
         if ((state_ff == ST_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= mexp_pkg::RESULT_WIDTH'(acc_ff);
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  shift_ff <= req_base;
                  exp_ff   <= req_exp;
                  cnt_ff   <= CW'(BW - 1);
                  sq_ff    <= '0;
                  ac_ff    <= '0;
                  if (req_exp == '0) begin
                     acc_ff   <= MW'(1);
                     state_ff <= ST_FINISH;
                  end else begin
                     acc_ff   <= (mod_full == (MW + 1)'(1)) ? '0 : MW'(1);
                     state_ff <= ST_REDUCE;
                  end
               end
            end
            ST_REDUCE: begin
               if (cnt_ff == '0) begin
                  base_ff  <= sq_in;
                  shift_ff <= BW'(sq_in);
                  sq_ff    <= '0;
                  cnt_ff   <= CW'(BW - 1);
                  state_ff <= ST_MULT;
               end else begin
                  shift_ff <= {shift_ff[BW-2:0], 1'b0};
                  sq_ff    <= sq_in;
                  cnt_ff   <= cnt_ff - CW'(1);
               end
            end
            ST_MULT: begin
               if (cnt_ff == '0) begin
                  // one exponent bit done: square always, multiply on a set bit
                  base_ff  <= sq_in;
                  shift_ff <= BW'(sq_in);
                  sq_ff    <= '0;
                  ac_ff    <= '0;
                  cnt_ff   <= CW'(BW - 1);
                  exp_ff   <= exp_ff >> 1;
                  if (exp_ff[0]) begin
                     acc_ff <= ac_in;
                  end
                  if ((exp_ff >> 1) == '0) begin
                     state_ff <= ST_FINISH;
                  end
               end else begin
                  shift_ff <= {shift_ff[BW-2:0], 1'b0};
                  sq_ff    <= sq_in;
                  ac_ff    <= ac_in;
                  cnt_ff   <= cnt_ff - CW'(1);
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/mexp_checker.sv]
// mexp_checker: port-level assertions for modular_exponentiation, bound to
// the top level. Depends on mexp_pkg.
`default_nettype none

module mexp_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [mexp_pkg::RESULT_WIDTH-1:0] rsp_tdata
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed under stall");

   // reset leaves no result pending
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // one item at a time: an accepted beat makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("new beat taken while item in flight");

   // a result only appears after the core was busy
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared without an item in flight");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);

`default_nettype wire
